// ----- src/cakb_pkg.sv -----
// Shared types, constants and helper functions for the color key alpha blur core.
// No dependencies; every other file in src/ except cakb_ram refers to this package by scoped names.
package cakb_pkg;

  // Field and bus widths
  localparam int PIX_W     = 32;
  localparam int ALPHA_W   = 8;
  localparam int ALPHA_LSB = 24;
  localparam int RGB_W     = 24;
  localparam int CFG_W     = 11;
  localparam int APB_DW    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_SEL_BIT = 2;

  // Position counters are sized for the largest geometry the 11-bit
  // registers can express: 2047 x 1024 pixels plus the drain of the blur passes.
  localparam int POS_W = 22;

  // Geometry limits and reset values
  localparam int MAX_LINE_WIDTH_DEF = 1024;
  localparam int BLUR_PASSES_DEF    = 4;
  localparam int MAX_LINE_COUNT     = 1024;
  localparam int LINE_WIDTH_MIN     = 3;
  localparam int LINE_COUNT_MIN     = 3;
  localparam int LINE_WIDTH_RST     = 64;
  localparam int LINE_COUNT_RST     = 64;

  // Derived geometry goes through three register stages after a write
  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  // Keying
  localparam logic [RGB_W-1:0]   KEY_RGB      = 24'hff00ff;
  localparam logic [ALPHA_W-1:0] OPAQUE_ALPHA = 8'hff;

  // Stencil sum is 2*c + 4 neighbors, at most 6*255 = 1530.
  // floor(s/6) == (s*683) >> 12 for all s below 1536.
  localparam int SUM_W      = 11;
  localparam int DIV6_MUL   = 683;
  localparam int DIV6_MUL_W = 10;
  localparam int DIV6_SHIFT = 12;
  localparam int PROD_W     = SUM_W + DIV6_MUL_W;

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_LINE_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             flush;
  } feed_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             image_end;
  } result_t;

  // Geometry derived from the registers, shared by all cells
  typedef struct packed {
    logic [CFG_W-1:0] wm2;       // width - 2
    logic [CFG_W-1:0] wm1;       // width - 1
    logic [POS_W-1:0] w_p1;      // width + 1
    logic [POS_W-1:0] w2_p2;     // 2*width + 2
    logic [POS_W-1:0] n;         // pixels per image
    logic [POS_W-1:0] n_w;       // n + width
    logic [POS_W-1:0] n_w1;      // n + width + 1
    logic [POS_W-1:0] end_step;  // last transaction of an image
  } geom_t;

  typedef struct packed {
    logic clear;  // register write: drop the image in progress
    logic busy;   // geometry still settling
  } cfg_ctl_t;

  // Token handed from one cell to the next
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] data;
    logic             in_range;  // position lies inside the image
    logic             last_pix;  // position is the last pixel
    logic             img_end;   // transaction closes the image
  } tok_t;

  function automatic logic [PIX_W-1:0] key_pixel(input logic [PIX_W-1:0] px);
    logic [RGB_W-1:0] rgb;
    rgb = px[RGB_W-1:0];
    if (rgb == KEY_RGB) begin
      return '0;
    end
    return {OPAQUE_ALPHA, rgb};
  endfunction

  function automatic logic [ALPHA_W-1:0] alpha_div6(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV6_MUL);
    return ALPHA_W'(prod >> DIV6_SHIFT);
  endfunction

endpackage

// ----- src/cakb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents. No dependencies.
module cakb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- src/cakb_cell.sv -----
// One blur pass: two line delays in RAM plus tap registers and the stencil datapath.
// Depends on cakb_pkg and cakb_ram.
module cakb_cell #(
  parameter int MAX_LINE_WIDTH = cakb_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            adv,
  input  cakb_pkg::geom_t geom,
  input  cakb_pkg::tok_t  up_tok,
  output cakb_pkg::tok_t  dn_tok
);

  // Delay A: w-1 tokens, full pixel. Delay B: w tokens, alpha only.
  localparam int A_DEPTH = MAX_LINE_WIDTH - 1;
  localparam int B_DEPTH = MAX_LINE_WIDTH;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  localparam int PW = cakb_pkg::PIX_W;
  localparam int AL = cakb_pkg::ALPHA_W;
  localparam int SW = cakb_pkg::SUM_W;

  logic [cakb_pkg::POS_W-1:0] p;
  logic [A_AW-1:0]            ca;
  logic [A_AW-1:0]            ca_next;
  logic [B_AW-1:0]            cb;
  logic [B_AW-1:0]            cb_next;

  // Taps around position pos = p - w - 1
  logic [PW-1:0] east;   // pos + 1 (delay A output)
  logic [PW-1:0] ctr;    // pos
  logic [AL-1:0] south;  // pos + w
  logic [AL-1:0] west;   // pos - 1
  logic [AL-1:0] north;  // pos - w (delay B output)

  logic          step;
  logic [SW-1:0] sum;
  logic [PW-1:0] blur;
  logic [PW-1:0] res;
  logic          emit;
  logic          in_range;
  logic          interior;
  logic          last;

  logic          dn_valid;
  logic [PW-1:0] dn_data;
  logic          dn_in_range;
  logic          dn_last;
  logic          dn_end;

  assign step = adv && up_tok.valid;

  cakb_ram #(.WIDTH(PW), .DEPTH(A_DEPTH)) u_dly_a (
    .clk   (clk),
    .we    (step),
    .waddr (ca),
    .wdata (up_tok.data),
    .re    (step),
    .raddr (ca),
    .rdata (east)
  );

  cakb_ram #(.WIDTH(AL), .DEPTH(B_DEPTH)) u_dly_b (
    .clk   (clk),
    .we    (step),
    .waddr (cb),
    .wdata (east[PW-1 -: AL]),
    .re    (step),
    .raddr (cb),
    .rdata (north)
  );

  always_comb begin
    sum = (SW'(ctr[PW-1 -: AL]) << 1) + SW'(east[PW-1 -: AL]) + SW'(west)
        + SW'(south) + SW'(north);
    blur = {cakb_pkg::alpha_div6(sum), ctr[cakb_pkg::ALPHA_LSB-1:0]};

    emit     = p >= geom.w_p1;
    in_range = p < geom.n_w1;
    interior = (p >= geom.w2_p2) && (p <= geom.n);
    last     = p == geom.n_w;

    if (!in_range) begin
      res = '0;
    end else if (interior) begin
      res = blur;
    end else begin
      res = ctr;
    end

    if (up_tok.img_end || (cakb_pkg::CFG_W'(ca) == geom.wm2)) begin
      ca_next = '0;
    end else begin
      ca_next = ca + A_AW'(1);
    end
    if (up_tok.img_end || (cakb_pkg::CFG_W'(cb) == geom.wm1)) begin
      cb_next = '0;
    end else begin
      cb_next = cb + B_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      p        <= '0;
      ca       <= '0;
      cb       <= '0;
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= step && emit;
      if (step) begin
        p  <= up_tok.img_end ? '0 : p + cakb_pkg::POS_W'(1);
        ca <= ca_next;
        cb <= cb_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      south       <= up_tok.data[PW-1 -: AL];
      ctr         <= east;
      west        <= ctr[PW-1 -: AL];
      dn_data     <= res;
      dn_in_range <= in_range;
      dn_last     <= last;
      dn_end      <= up_tok.img_end;
    end
  end

  assign dn_tok = '{valid: dn_valid, data: dn_data, in_range: dn_in_range,
                    last_pix: dn_last, img_end: dn_end};

endmodule

// ----- src/cakb_cfg.sv -----
// APB register file (line_width, line_count) and the derived geometry pipeline.
// Depends on cakb_pkg.
module cakb_cfg #(
  parameter int MAX_LINE_WIDTH = cakb_pkg::MAX_LINE_WIDTH_DEF,
  parameter int BLUR_PASSES    = cakb_pkg::BLUR_PASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cakb_pkg::ADDR_W-1:0]   paddr,
  input  logic [cakb_pkg::APB_DW-1:0]   pwdata,
  output logic [cakb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output cakb_pkg::geom_t               geom,
  output cakb_pkg::cfg_ctl_t            ctl
);

  localparam int CW = cakb_pkg::CFG_W;
  localparam int PW = cakb_pkg::POS_W;

  logic [CW-1:0] line_width;
  logic [CW-1:0] line_count;
  logic          wr;
  cakb_pkg::cfg_reg_t sel;

  logic [cakb_pkg::SETTLE_W-1:0] settle;

  // stage 1
  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;
  // stage 2
  logic [CW-1:0] wm1;
  logic [CW-1:0] wm2;
  logic [PW-1:0] w_p1;
  logic [PW-1:0] w2_p2;
  logic [PW-1:0] n;
  logic [PW-1:0] bw;
  // stage 3
  logic [PW-1:0] n_w;
  logic [PW-1:0] n_w1;
  logic [PW-1:0] end_step;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = cakb_pkg::cfg_reg_t'(paddr[cakb_pkg::REG_SEL_BIT]);

  always_comb begin
    case (sel)
      cakb_pkg::REG_LINE_WIDTH: prdata = cakb_pkg::APB_DW'(line_width);
      cakb_pkg::REG_LINE_COUNT: prdata = cakb_pkg::APB_DW'(line_count);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= CW'(cakb_pkg::LINE_WIDTH_RST);
      line_count <= CW'(cakb_pkg::LINE_COUNT_RST);
      settle     <= cakb_pkg::SETTLE_W'(cakb_pkg::SETTLE_CYCLES);
    end else begin
      if (wr) begin
        case (sel)
          cakb_pkg::REG_LINE_WIDTH: line_width <= pwdata[CW-1:0];
          cakb_pkg::REG_LINE_COUNT: line_count <= pwdata[CW-1:0];
          default: ;
        endcase
        settle <= cakb_pkg::SETTLE_W'(cakb_pkg::SETTLE_CYCLES);
      end else if (settle != '0) begin
        settle <= settle - cakb_pkg::SETTLE_W'(1);
      end
    end
  end

  // Saturate, then build the compare constants over three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= '0;
      h_eff    <= '0;
      wm1      <= '0;
      wm2      <= '0;
      w_p1     <= '0;
      w2_p2    <= '0;
      n        <= '0;
      bw       <= '0;
      n_w      <= '0;
      n_w1     <= '0;
      end_step <= '0;
    end else begin
      if (line_width < CW'(cakb_pkg::LINE_WIDTH_MIN)) begin
        w_eff <= CW'(cakb_pkg::LINE_WIDTH_MIN);
      end else if (32'(line_width) > 32'(MAX_LINE_WIDTH)) begin
        w_eff <= CW'(MAX_LINE_WIDTH);
      end else begin
        w_eff <= line_width;
      end
      if (line_count < CW'(cakb_pkg::LINE_COUNT_MIN)) begin
        h_eff <= CW'(cakb_pkg::LINE_COUNT_MIN);
      end else if (32'(line_count) > 32'(cakb_pkg::MAX_LINE_COUNT)) begin
        h_eff <= CW'(cakb_pkg::MAX_LINE_COUNT);
      end else begin
        h_eff <= line_count;
      end

      wm1   <= w_eff - CW'(1);
      wm2   <= w_eff - CW'(2);
      w_p1  <= PW'(w_eff) + PW'(1);
      w2_p2 <= (PW'(w_eff) << 1) + PW'(2);
      n     <= PW'(w_eff) * PW'(h_eff);
      bw    <= PW'(BLUR_PASSES) * (PW'(w_eff) + PW'(1));

      n_w      <= n + w_p1 - PW'(1);
      n_w1     <= n + w_p1;
      end_step <= n + bw - PW'(1);
    end
  end

  assign geom = '{wm2: wm2, wm1: wm1, w_p1: w_p1, w2_p2: w2_p2, n: n,
                  n_w: n_w, n_w1: n_w1, end_step: end_step};
  assign ctl  = '{clear: wr, busy: settle != '0};

endmodule

// ----- src/color_key_alpha_blur_core.sv -----
// Top level of the color key alpha blur core: input control, cell chain, result port.
// Depends on cakb_pkg, cakb_cfg, cakb_cell (and through it cakb_ram).
//
// Streams a raster image one pixel per transaction in row order. Each pixel
// loses its alpha byte; RGB equal to magenta 0xff00ff becomes transparent
// black, anything else gets alpha 0xff. BLUR_PASSES cells in a row then each
// blur alpha with the cross stencil (2*c + left + right + up + down) / 6 on
// linear indices, so left/right wrap across row ends; pixels in the first
// line_width+1 and the last line_width positions keep their alpha. Sustained
// rate is one transaction per clock unless the sink stalls or the geometry
// settles: every cell does one write and one read of each of its two line
// delays (RAM of line_width-1 pixels and line_width alpha bytes) per
// transaction. The result for pixel q leaves with input transaction q +
// BLUR_PASSES*(line_width+1); after the last pixel, send flush transactions
// (or pixels, which are then dropped) to drain it. A flush while the image
// is still filling is taken and ignored. image_end marks the last pixel; the
// next pixel starts a new image. Widths outside [3, MAX_LINE_WIDTH] and row
// counts outside [3, 1024] are saturated. A register write abandons the
// image in progress and holds off input while the geometry is recomputed,
// as after reset. Write registers only when the core is idle.
module color_key_alpha_blur_core #(
  parameter int MAX_LINE_WIDTH = cakb_pkg::MAX_LINE_WIDTH_DEF,
  parameter int BLUR_PASSES    = cakb_pkg::BLUR_PASSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input channel
  input  logic                        feed_valid,
  output logic                        feed_stall,
  input  cakb_pkg::feed_t             feed,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output cakb_pkg::result_t           result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cakb_pkg::ADDR_W-1:0] paddr,
  input  logic [cakb_pkg::APB_DW-1:0] pwdata,
  output logic [cakb_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int PW = cakb_pkg::POS_W;

  cakb_pkg::geom_t    geom;
  cakb_pkg::cfg_ctl_t ctl;

  // tok[0] enters the first cell, tok[BLUR_PASSES] leaves the last one
  cakb_pkg::tok_t tok [BLUR_PASSES+1];

  logic          adv;       // whole chain moves
  logic          accept;    // input transaction taken
  logic          filling;   // image still receiving pixels
  logic          tok_go;    // transaction becomes a token
  logic          tok_end;   // token closes the image
  logic [PW-1:0] ip;        // pixels received in this image
  logic [PW-1:0] step_cnt;  // tokens sent in this image

  cakb_cfg #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .BLUR_PASSES    (BLUR_PASSES)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .ctl     (ctl)
  );

  // The last cell's output register is the result register; the chain only
  // freezes while a result is held by a stalled receiver.
  assign adv        = !(result_valid && result_stall);
  assign feed_stall = !adv || ctl.busy;
  assign accept     = feed_valid && !feed_stall;

  assign filling = ip < geom.n;
  // a flush during filling is swallowed; once filled every transaction drains
  assign tok_go  = accept && (!filling || !feed.flush);
  assign tok_end = step_cnt == geom.end_step;

  assign tok[0] = '{valid: tok_go,
                    data: filling ? cakb_pkg::key_pixel(feed.pixel_in) : '0,
                    in_range: 1'b0, last_pix: 1'b0, img_end: tok_end};

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      ip       <= '0;
      step_cnt <= '0;
    end else if (tok_go) begin
      if (tok_end) begin
        ip       <= '0;
        step_cnt <= '0;
      end else begin
        step_cnt <= step_cnt + PW'(1);
        if (filling) begin
          ip <= ip + PW'(1);
        end
      end
    end
  end

  for (genvar k = 0; k < BLUR_PASSES; k++) begin : g_cell
    cakb_cell #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .clear  (ctl.clear),
      .adv    (adv),
      .geom   (geom),
      .up_tok (tok[k]),
      .dn_tok (tok[k+1])
    );
  end

  // Drain tokens past the image end travel the chain but produce nothing
  assign result_valid = tok[BLUR_PASSES].valid && tok[BLUR_PASSES].in_range;
  assign result       = '{pixel_out: tok[BLUR_PASSES].data,
                          image_end: tok[BLUR_PASSES].last_pix};

  // Image-end marker from the input counter must meet the last pixel
  // as seen by the final cell's own position counter.
  a_end_aligned: assert property (@(posedge clk) disable iff (rst)
    tok[BLUR_PASSES].valid && tok[BLUR_PASSES].img_end
      |-> tok[BLUR_PASSES].in_range && tok[BLUR_PASSES].last_pix)
    else $error("image end marker not on last pixel");

  // While filling, every token carries a pixel
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    filling |-> step_cnt == ip)
    else $error("token count diverged from pixel count");

  // A register write abandons the image
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (ip == '0) && (step_cnt == '0))
    else $error("counters not cleared by register write");

endmodule

// ----- tb/color_key_alpha_blur_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for color_key_alpha_blur_core: directed and random pixel streams,
// APB register writes between images, and a scoreboard that predicts the keyed, blurred pixels.
// Depends on cakb_pkg and the core RTL under src/.
module color_key_alpha_blur_core_tb;

  localparam int PASSES       = cakb_pkg::BLUR_PASSES_DEF;
  localparam int RING_MAX     = 2 * cakb_pkg::MAX_LINE_WIDTH_DEF + 2;
  // cell registers plus the geometry settle after a write, with slack
  localparam int DRAIN_PAUSE  = 32;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 460;
  localparam int MAX_REPORTS  = 10;

  // Scoreboard: keeps its own copy of the registers and of each blur stage's
  // line ring, predicts the result of every accepted transaction and checks
  // results in order against the oldest prediction.
  class blur_scoreboard;
    logic [cakb_pkg::CFG_W-1:0] width_reg;
    logic [cakb_pkg::CFG_W-1:0] count_reg;
    logic [cakb_pkg::PIX_W-1:0] ring_store [PASSES][RING_MAX];
    int unsigned                stage_pos [PASSES];
    int unsigned                pixels_taken;
    cakb_pkg::result_t          pending_pixels [$];
    int                         mismatches;

    function new();
      width_reg  = cakb_pkg::CFG_W'(cakb_pkg::LINE_WIDTH_RST);
      count_reg  = cakb_pkg::CFG_W'(cakb_pkg::LINE_COUNT_RST);
      mismatches = 0;
      foreach (ring_store[k, i]) ring_store[k][i] = '0;
      restart_image();
    endfunction

    function void restart_image();
      foreach (stage_pos[k]) stage_pos[k] = 0;
      pixels_taken = 0;
    endfunction

    // register values are clamped when used, not when written
    function int unsigned line_px();
      int unsigned w;
      w = width_reg;
      if (w < cakb_pkg::LINE_WIDTH_MIN) w = cakb_pkg::LINE_WIDTH_MIN;
      if (w > cakb_pkg::MAX_LINE_WIDTH_DEF) w = cakb_pkg::MAX_LINE_WIDTH_DEF;
      return w;
    endfunction

    function int unsigned line_rows();
      int unsigned h;
      h = count_reg;
      if (h < cakb_pkg::LINE_COUNT_MIN) h = cakb_pkg::LINE_COUNT_MIN;
      if (h > cakb_pkg::MAX_LINE_COUNT) h = cakb_pkg::MAX_LINE_COUNT;
      return h;
    endfunction

    function void set_register(cakb_pkg::cfg_reg_t r, logic [cakb_pkg::APB_DW-1:0] v);
      if (r == cakb_pkg::REG_LINE_WIDTH) width_reg = v[cakb_pkg::CFG_W-1:0];
      else count_reg = v[cakb_pkg::CFG_W-1:0];
      restart_image();
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function int unsigned alpha_at(int k, int unsigned p, int unsigned ring);
      logic [cakb_pkg::PIX_W-1:0] px;
      px = ring_store[k][p % ring];
      return px[cakb_pkg::PIX_W-1:cakb_pkg::ALPHA_LSB];
    endfunction

    // cross stencil on linear positions; borders pass through untouched
    function logic [cakb_pkg::PIX_W-1:0] blurred(int k, int unsigned q, int unsigned w,
                                                 int unsigned n, int unsigned ring);
      logic [cakb_pkg::PIX_W-1:0] c;
      int unsigned                sum;
      c = ring_store[k][q % ring];
      if (q >= w + 1 && q + w < n) begin
        sum = 2 * alpha_at(k, q, ring) + alpha_at(k, q + 1, ring) + alpha_at(k, q - 1, ring)
            + alpha_at(k, q + w, ring) + alpha_at(k, q - w, ring);
        return {cakb_pkg::ALPHA_W'(sum / 6), c[cakb_pkg::RGB_W-1:0]};
      end
      return c;
    endfunction

    function void note_feed(cakb_pkg::feed_t f);
      int unsigned                w, n, ring, p, pos;
      logic [cakb_pkg::PIX_W-1:0] val;
      bit                         live;
      cakb_pkg::result_t          r;
      w    = line_px();
      n    = w * line_rows();
      ring = 2 * w + 2;
      val  = '0;
      pos  = 0;
      live = 1'b1;
      if (pixels_taken < n) begin
        // still filling: a flush is swallowed with no effect
        if (f.flush) return;
        val = (f.pixel_in[cakb_pkg::RGB_W-1:0] == cakb_pkg::KEY_RGB) ? '0 :
              {cakb_pkg::OPAQUE_ALPHA, f.pixel_in[cakb_pkg::RGB_W-1:0]};
        pixels_taken++;
      end
      // draining otherwise: any transaction, pixel or flush, just advances the stages
      for (int k = 0; k < PASSES && live; k++) begin
        p = stage_pos[k];
        if (p < n) ring_store[k][p % ring] = val;
        stage_pos[k] = p + 1;
        if (p >= w + 1) begin
          pos = p - (w + 1);
          val = (pos < n) ? blurred(k, pos, w, n, ring) : '0;
        end else begin
          live = 1'b0;
        end
      end
      if (!live || pos >= n) return;
      r.pixel_out = val;
      r.image_end = (pos == n - 1);
      pending_pixels.push_back(r);
      if (r.image_end) restart_image();
    endfunction

    function void check_result(cakb_pkg::result_t got);
      cakb_pkg::result_t want;
      if (pending_pixels.size() == 0) begin
        log_mismatch($sformatf("unexpected result pixel_out %08h image_end %b",
                               got.pixel_out, got.image_end));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out)
        log_mismatch($sformatf("pixel_out expected %08h got %08h", want.pixel_out, got.pixel_out));
      if (got.image_end !== want.image_end)
        log_mismatch($sformatf("image_end expected %b got %b (pixel_out %08h)",
                               want.image_end, got.image_end, want.pixel_out));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          feed_valid = 1'b0;
  logic                          feed_stall;
  cakb_pkg::feed_t               feed = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  cakb_pkg::result_t             result;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cakb_pkg::ADDR_W-1:0]   paddr = '0;
  logic [cakb_pkg::APB_DW-1:0]   pwdata = '0;
  logic [cakb_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  blur_scoreboard sb;
  int idle_pct = 0;        // chance per cycle that the source holds off
  int stall_pct = 0;       // chance per cycle that the sink stalls
  int cycle_count = 0;
  int counted_items = 0;   // transactions that the core actually acts on

  color_key_alpha_blur_core dut (.*);

  always #5 clk = ~clk;

  // Hard stop in case the core hangs or drops results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("color_key_alpha_blur_core verification failed");
      $finish;
    end
  end

  // Monitor: both channels sampled at the rising edge, results checked before
  // the new input transaction is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_result(result);
      if (feed_valid && !feed_stall) sb.note_feed(feed);
    end
  end

  // Sink backpressure, independent of everything else
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic cakb_pkg::feed_t pixel_item(logic [cakb_pkg::PIX_W-1:0] v);
    cakb_pkg::feed_t f;
    f.pixel_in = v;
    f.flush    = 1'b0;
    return f;
  endfunction

  function automatic cakb_pkg::feed_t flush_item();
    cakb_pkg::feed_t f;
    f.pixel_in = $urandom;
    f.flush    = 1'b1;
    return f;
  endfunction

  // Mix of plain pixels, exact magenta keys and keys one RGB bit off;
  // the alpha byte is always random since the core must ignore it.
  function automatic logic [cakb_pkg::PIX_W-1:0] random_pixel();
    logic [cakb_pkg::PIX_W-1:0] v;
    int                         b;
    v = $urandom;
    b = $urandom_range(cakb_pkg::RGB_W - 1);
    case ($urandom_range(7))
      0, 1: v[cakb_pkg::RGB_W-1:0] = cakb_pkg::KEY_RGB;
      2: begin
        v[cakb_pkg::RGB_W-1:0] = cakb_pkg::KEY_RGB;
        v[b] = ~v[b];
      end
      default: ;
    endcase
    return v;
  endfunction

  // Traffic phases: clean, idle source, stalling sink, both a little
  task automatic set_traffic(int phase);
    case (phase % 4)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 66;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 66;
      end
      default: begin
        idle_pct  = 19;
        stall_pct = 19;
      end
    endcase
  endtask

  // One transaction: optional idle cycles, then hold until accepted.
  // Valid is only ever assigned once per falling edge.
  task automatic send_item(cakb_pkg::feed_t f);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      feed_valid <= 1'b0;
      @(negedge clk);
    end
    feed_valid <= 1'b1;
    feed       <= f;
    @(posedge clk);
    while (feed_stall) @(posedge clk);
  endtask

  task automatic feed_quiet();
    @(negedge clk);
    feed_valid <= 1'b0;
  endtask

  // Source goes quiet until every predicted result is out, then lets the
  // cell registers empty.
  task automatic wait_drained();
    feed_quiet();
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // APB read of one register, compared against the expected value
  task automatic read_reg(cakb_pkg::cfg_reg_t r, logic [cakb_pkg::APB_DW-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= cakb_pkg::ADDR_W'(r) << cakb_pkg::REG_SEL_BIT;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      sb.log_mismatch($sformatf("%s read expected %0d got %0d", r.name(), want, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write followed by a read back of the same register; only done idle.
  task automatic write_reg(cakb_pkg::cfg_reg_t r, logic [cakb_pkg::APB_DW-1:0] v);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cakb_pkg::ADDR_W'(r) << cakb_pkg::REG_SEL_BIT;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(r, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== cakb_pkg::APB_DW'(v[cakb_pkg::CFG_W-1:0]))
      sb.log_mismatch($sformatf("%s read back expected %0d got %0d",
                                r.name(), v[cakb_pkg::CFG_W-1:0], prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A whole image: every pixel (with stray flushes that the core must ignore
  // while filling), then enough drain transactions to push the last pixel out.
  // Some drain transactions carry a pixel, which the core must drop.
  task automatic run_image(int noise_pct, bit hold_mid);
    int unsigned w, n, tail;
    w    = sb.line_px();
    n    = w * sb.line_rows();
    tail = PASSES * (w + 1);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(flush_item());
      send_item(pixel_item(random_pixel()));
      counted_items++;
    end
    for (int unsigned i = 0; i < tail; i++) begin
      if (hold_mid && i == tail / 2) begin
        // source pauses mid drain until the sink has caught up completely
        feed_quiet();
        while (sb.pending_pixels.size() != 0) @(posedge clk);
      end
      send_item(($urandom_range(4) == 0) ? pixel_item(random_pixel()) : flush_item());
      counted_items++;
    end
  endtask

  initial begin
    logic [cakb_pkg::PIX_W-1:0] corner_pixels [9];
    int                         img;
    int                         start_items;
    sb = new();
    corner_pixels = '{32'h0000_0000, 32'hffff_ffff, 32'h00ff_00ff,
                      32'hffff_00ff, 32'h12ff_00fe, 32'h7fff_01ff,
                      32'h80fe_00ff, 32'h00ff_ffff, 32'hff00_0000};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Register values straight out of reset
    set_traffic(0);
    read_reg(cakb_pkg::REG_LINE_WIDTH, cakb_pkg::APB_DW'(cakb_pkg::LINE_WIDTH_RST));
    read_reg(cakb_pkg::REG_LINE_COUNT, cakb_pkg::APB_DW'(cakb_pkg::LINE_COUNT_RST));

    // Width 0 and row count 2 both clamp to the 3 x 3 minimum
    write_reg(cakb_pkg::REG_LINE_WIDTH, 0);
    write_reg(cakb_pkg::REG_LINE_COUNT, 2);
    // all-zero, all-ones, magenta with either alpha, near misses on each channel
    foreach (corner_pixels[i]) begin
      send_item(pixel_item(corner_pixels[i]));
      if (i == 2) send_item(flush_item());    // swallowed, image still filling
    end
    for (int i = 0; i < PASSES * (cakb_pkg::LINE_WIDTH_MIN + 1); i++)
      send_item((i == 5) ? pixel_item(32'hffff_ffff) : flush_item());  // pixel is dropped

    // Partial image, then a register write that abandons it
    for (int i = 0; i < 4; i++) send_item(pixel_item(random_pixel()));
    write_reg(cakb_pkg::REG_LINE_COUNT, 3);

    // Upper pwdata bits must be ignored; large values read back unclamped
    write_reg(cakb_pkg::REG_LINE_WIDTH, 32'hffff_f7ff);
    write_reg(cakb_pkg::REG_LINE_COUNT, 1100);

    // Random images, mostly small, cycling through the traffic phases
    img         = 0;
    start_items = counted_items;
    while (counted_items - start_items < RANDOM_ITEMS) begin
      set_traffic(img);
      if (img == 0 || $urandom_range(3) != 0) begin
        write_reg(cakb_pkg::REG_LINE_WIDTH,
                  ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10));
        write_reg(cakb_pkg::REG_LINE_COUNT,
                  ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6));
      end
      run_image(10, img == 2);
      img++;
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("color_key_alpha_blur_core verification clean");
    end else begin
      $display("color_key_alpha_blur_core verification failed");
    end
    $finish;
  end

endmodule
